// ===== hdl/rws_pkg.sv =====
// ============================================================================
// rws_pkg
// Shared widths and constants for the roulette wheel selection block.
// ============================================================================
package rws_pkg;

    localparam int MAX_POPULATION  = 64;
    localparam int ADDR_W          = $clog2(MAX_POPULATION);
    localparam int CNT_W           = $clog2(MAX_POPULATION + 1);

    localparam int OP_W            = 1;
    localparam int INDEX_W         = 6;
    localparam int FIT_W           = 16;
    localparam int TOTAL_W         = 22;
    localparam int RND_W           = 31;
    localparam int POP_W           = 7;

    localparam int ACC_W           = FIT_W + ADDR_W;
    localparam int CMP_W           = (ACC_W > TOTAL_W) ? ACC_W : TOTAL_W;
    localparam int STEP_W          = $clog2(RND_W);

    localparam logic [OP_W-1:0]    OP_LOAD   = 1'b0;
    localparam logic [OP_W-1:0]    OP_SELECT = 1'b1;

    localparam logic [TOTAL_W-1:0] POINT_THRESHOLD = TOTAL_W'(100);
    localparam logic [POP_W-1:0]   POP_RESET       = POP_W'(1);

endpackage

// ===== hdl/rws_if.sv =====
// ============================================================================
// rws_in_if / rws_out_if
// Valid/ready channels for request items and selection results.
// ============================================================================
interface rws_in_if;
    import rws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [INDEX_W-1:0]   entry_index;
    logic [FIT_W-1:0]     fitness_value;
    logic [TOTAL_W-1:0]   total_fitness;
    logic [RND_W-1:0]     random_value;

    modport source (output valid, op, entry_index, fitness_value, total_fitness,
                    random_value, input ready);
    modport sink   (input valid, op, entry_index, fitness_value, total_fitness,
                    random_value, output ready);
endinterface

interface rws_out_if;
    import rws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   chosen_index;
    logic                 not_found;

    modport source (output valid, chosen_index, not_found, input ready);
    modport sink   (input valid, chosen_index, not_found, output ready);
endinterface

// ===== hdl/roulette_wheel_select_top.sv =====
// Load transfer: written to the table at the accepting edge.
// Select transfer: a setup state (total below POINT_THRESHOLD) or a bit-serial
// remainder over the 31 dividend bits, then a scan of up to 64 entries, one per cycle,
// then the output register, via a done state held while the last result waits.
// One item at a time; input ready only while the sequencer is idle.
// Reset clears control state and sets pop_reg to 1; table is not cleared.
// ============================================================================
// roulette_wheel_select_top
// Fitness-proportionate selection over a table of fitness values.
// ============================================================================
module roulette_wheel_select_top (
    input  logic                        clk,
    input  logic                        rst_n,
    rws_in_if.sink                      in_ch,
    rws_out_if.source                   out_ch,
    input  logic                        cfg_wr_en,
    input  logic [rws_pkg::POP_W-1:0]   cfg_wr_data
);
    import rws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [POP_W-1:0]     pop_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [TOTAL_W-1:0]   point_reg;
    logic [INDEX_W-1:0]   res_idx_reg;
    logic                 res_nf_reg;
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_idx_reg;
    logic                 out_nf_reg;

    logic                 accept;
    logic                 is_load;
    logic                 total_big;
    logic                 load_ok;
    logic                 mod_start;
    logic                 mod_done;
    logic [TOTAL_W-1:0]   mod_rem;
    logic [ADDR_W-1:0]    rd_addr;
    logic [FIT_W-1:0]     rd_data;
    logic [ACC_W-1:0]     acc_sum;
    logic                 hit;
    logic                 last;
    logic [CNT_W-1:0]     count_clamp;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_load     = (in_ch.op == OP_LOAD);
    assign total_big   = (in_ch.total_fitness >= POINT_THRESHOLD);
    assign load_ok     = ({1'b0, in_ch.entry_index} < (INDEX_W + 1)'(MAX_POPULATION));
    assign mod_start   = accept && !is_load && total_big;

    assign count_clamp = (CNT_W'(pop_reg) > CNT_W'(MAX_POPULATION))
                         ? CNT_W'(MAX_POPULATION) : CNT_W'(pop_reg);

    assign rd_addr = (state_reg == ST_SCAN) ? ADDR_W'(idx_reg + 1'b1) : '0;
    assign acc_sum = acc_reg + ACC_W'(rd_data);
    assign hit     = (CMP_W'(acc_sum) >= CMP_W'(point_reg));
    assign last    = ((CNT_W'(idx_reg) + 1'b1) == count_reg);

    rws_fit_table u_table (
        .clk     (clk),
        .wr_en   (accept && is_load && load_ok),
        .wr_addr (ADDR_W'(in_ch.entry_index)),
        .wr_data (in_ch.fitness_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rws_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_ch.random_value),
        .divisor   (in_ch.total_fitness),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pop_reg       <= POP_RESET;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            point_reg     <= '0;
            res_idx_reg   <= '0;
            res_nf_reg    <= 1'b0;
            out_idx_reg   <= '0;
            out_nf_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pop_reg <= cfg_wr_data;
            end

            if (out_valid_reg && out_ch.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !is_load)
                    begin
                        count_reg <= count_clamp;
                        idx_reg   <= '0;
                        acc_reg   <= '0;
                        point_reg <= '0;
                        state_reg <= total_big ? ST_MOD : ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_MOD:
                begin
                    if (mod_done)
                    begin
                        point_reg <= mod_rem;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (count_reg == '0)
                    begin
                        res_idx_reg <= '0;
                        res_nf_reg  <= 1'b1;
                        state_reg   <= ST_DONE;
                    end
                    else if (hit)
                    begin
                        res_idx_reg <= INDEX_W'(idx_reg);
                        res_nf_reg  <= 1'b0;
                        state_reg   <= ST_DONE;
                    end
                    else if (last)
                    begin
                        res_idx_reg <= '0;
                        res_nf_reg  <= 1'b1;
                        state_reg   <= ST_DONE;
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= res_idx_reg;
                        out_nf_reg    <= res_nf_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.chosen_index = out_idx_reg;
    assign out_ch.not_found    = out_nf_reg;

endmodule

// ===== hdl/rws_fit_table.sv =====
// ============================================================================
// rws_fit_table
// Fitness table: one write port, one read port with registered read data.
// ============================================================================
module rws_fit_table (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [rws_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [rws_pkg::FIT_W-1:0]   wr_data,
    input  logic [rws_pkg::ADDR_W-1:0]  rd_addr,
    output logic [rws_pkg::FIT_W-1:0]   rd_data
);
    import rws_pkg::*;

    logic [FIT_W-1:0] mem [MAX_POPULATION];
    logic [FIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rws_mod_unit.sv =====
// ============================================================================
// rws_mod_unit
// Restoring remainder unit: one dividend bit per cycle over the RND_W dividend bits.
// ============================================================================
module rws_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rws_pkg::RND_W-1:0]    dividend,
    input  logic [rws_pkg::TOTAL_W-1:0]  divisor,
    output logic                         done,
    output logic [rws_pkg::TOTAL_W-1:0]  remainder
);
    import rws_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [RND_W-1:0]    dvd_reg;
    logic [TOTAL_W-1:0]  dvs_reg;
    logic [TOTAL_W-1:0]  rem_reg;
    logic [TOTAL_W-1:0]  rem_next;
    logic [TOTAL_W:0]    trial;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[RND_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = TOTAL_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(RND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
